/* rtl/ntr_pkg.sv */
// Package: shared types, widths and compact-target helpers for the retarget block.
package ntr_pkg;

  // Remainder width: the divisor (I+1)*S stays below 2^21 over all parameter ranges.
  localparam int REM_W = 21;

  typedef struct packed {
    logic        fixed;     // result already known, skip the arithmetic
    logic [31:0] alt;       // fixed result, or encoded limit for a retarget
    logic [31:0] lim_bits;  // compact limit used for the range check
    logic        dsel;      // 1: v2 spacing divisor, 0: v1 spacing divisor
  } side_t;

  typedef struct packed {
    logic [255:0] acc;
    logic [255:0] t;
    logic [63:0]  m;
    side_t        side;
  } mul_t;

  typedef struct packed {
    logic [255:0]     word;   // dividend bytes, replaced by quotient bytes as they form
    logic [REM_W-1:0] rem;
    logic             found;  // a nonzero quotient byte has been seen
    logic [1:0]       n;      // bytes captured in the window
    logic [5:0]       sz;     // compact size of the quotient
    logic [23:0]      win;    // leading three quotient bytes
    side_t            side;
  } div_t;

  // Expand a compact target to 256 bits; the sign bit is ignored.
  function automatic logic [255:0] decode(logic [31:0] c);
    logic [7:0]   e;
    logic [255:0] v;
    logic [10:0]  sh;
    e  = c[31:24];
    v  = {233'b0, c[22:0]};
    sh = 11'd0;
    if (e <= 8'd3) begin
      sh = {3'b0, 8'd3 - e} << 3;
      v  = v >> sh;
    end else begin
      sh = {3'b0, e - 8'd3} << 3;
      v  = v << sh;
    end
    return v;
  endfunction

  // Canonical compact form of a compact value: encode(decode(c)) on narrow logic.
  function automatic logic [31:0] enc_dec(logic [31:0] c);
    logic [7:0]  e;
    logic [7:0]  b0, b1, b2;
    logic [22:0] v;
    logic [7:0]  sz;
    logic [23:0] cc;
    e  = c[31:24];
    b0 = c[7:0];
    b1 = c[15:8];
    b2 = {1'b0, c[22:16]};
    v  = 23'd0;
    sz = 8'd0;
    cc = 24'd0;
    if (e <= 8'd3) begin
      v = c[22:0] >> ({2'b0, 3'd3 - e[2:0]} << 3);
      if (v[22:16] != 7'd0) begin
        sz = 8'd3;
        cc = {1'b0, v};
      end else if (v[15:8] != 8'd0) begin
        sz = 8'd2;
        cc = {v[15:0], 8'd0};
      end else if (v[7:0] != 8'd0) begin
        sz = 8'd1;
        cc = {v[7:0], 16'd0};
      end
    end else begin
      if (b2 != 8'd0 && e <= 8'd32) begin
        sz = e;
        cc = {b2, b1, b0};
      end else if (b1 != 8'd0 && e <= 8'd33) begin
        sz = e - 8'd1;
        cc = {b1, b0, 8'd0};
      end else if (b0 != 8'd0 && e <= 8'd34) begin
        sz = e - 8'd2;
        cc = {b0, 16'd0};
      end
    end
    if (cc[23]) begin
      cc = cc >> 8;
      sz = sz + 8'd1;
    end
    return {sz, cc};
  endfunction

endpackage

/* rtl/ntr_if.sv */
// Interfaces: request and result channels with valid/ready handshake.
interface ntr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  chain_position;
  logic        proof_of_stake;
  logic [30:0] new_height;
  logic [31:0] tip_time;
  logic [31:0] last_bits;
  logic [31:0] last_time;
  logic [31:0] first_time;

  modport source (output valid, chain_position, proof_of_stake, new_height, tip_time,
                  last_bits, last_time, first_time, input ready);
  modport sink (input valid, chain_position, proof_of_stake, new_height, tip_time,
                last_bits, last_time, first_time, output ready);
endinterface

interface ntr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_bits;

  modport source (output valid, next_bits, input ready);
  modport sink (input valid, next_bits, output ready);
endinterface

/* rtl/ntr_mul_cell.sv */
// Multiply cell: one 32x32 partial product of target limb and multiplier half.
module ntr_mul_cell #(
  parameter int LI = 0,
  parameter int MJ = 0
) (
  input  logic          clk,
  input  logic [1:0]    en,
  input  ntr_pkg::mul_t din,
  output ntr_pkg::mul_t dout
);

  localparam int SH = 32 * (LI + MJ);

  ntr_pkg::mul_t mid;
  ntr_pkg::mul_t nxt;
  logic [63:0]   prod;

  // Fold the partial product into the running sum, modulo 2^256.
  always_comb begin
    nxt     = mid;
    nxt.acc = mid.acc + ({192'b0, prod} << SH);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mid  <= din;
      prod <= 64'(din.t[32*LI +: 32]) * 64'(din.m[32*MJ +: 32]);
    end
    if (en[1]) begin
      dout <= nxt;
    end
  end

endmodule

/* rtl/ntr_div_cell.sv */
// Divide cell: eight restoring steps on one dividend byte, plus leading-byte capture.
module ntr_div_cell #(
  parameter int BI = 31,
  parameter int D0 = 1,
  parameter int D1 = 1
) (
  input  logic          clk,
  input  logic          en,
  input  ntr_pkg::div_t din,
  output ntr_pkg::div_t dout
);

  localparam int RW = ntr_pkg::REM_W;

  ntr_pkg::div_t nxt;
  logic [RW:0]   dv;
  logic [RW:0]   x;
  logic [RW-1:0] r;
  logic [7:0]    q;

  always_comb begin
    nxt = din;
    dv  = din.side.dsel ? (RW+1)'(D1) : (RW+1)'(D0);
    r   = din.rem;
    q   = 8'd0;
    x   = '0;
    for (int b = 7; b >= 0; b--) begin
      x = {r, din.word[8*BI + b]};
      if (x >= dv) begin
        x    = x - dv;
        q[b] = 1'b1;
      end
      r = x[RW-1:0];
    end
    nxt.rem = r;
    nxt.word[8*BI +: 8] = q;
    if (!din.found) begin
      if (q != 8'd0) begin
        nxt.found = 1'b1;
        nxt.sz    = 6'(BI + 1);
        nxt.win   = {q, 16'd0};
        nxt.n     = 2'd1;
      end
    end else begin
      case (din.n)
        2'd1: begin
          nxt.win[15:8] = q;
          nxt.n         = 2'd2;
        end
        2'd2: begin
          nxt.win[7:0] = q;
          nxt.n        = 2'd3;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

/* rtl/next_target_retarget.sv */
// Top level: exponential compact-target retarget over a row of multiply and divide cells.
//
// next_target_retarget returns one compact target per request, one request per clock
// while no stall holds the row. Every item passes 65 register stages: one setup stage
// (limit choice, spacing, multiplier, target decode), 15 multiply cells of two stages each
// (a 32x32 product, then a 256-bit accumulate), 32 divide cells that each retire one
// quotient byte, a limit-decode stage, and the output register. Each stage moves forward
// whenever the stage after it is empty or moving, so bubbles close up and new items are
// taken while a result waits at the output. Genesis, first and second block requests and
// no-retarget blocks travel the same row and keep their order. Registers sit on an APB
// port at 4*index.
module next_target_retarget #(
  parameter int TARGET_SPACING    = 64,
  parameter int TARGET_SPACING_V1 = 60,
  parameter int TARGET_TIMESPAN   = 960,
  parameter int WORK_NO_RETARGET  = 0,
  parameter int STAKE_NO_RETARGET = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ntr_in_if.sink      in_ch,
  ntr_out_if.source   out_ch
);

  // Register indexes
  localparam logic [2:0] R_WORK_LIM  = 3'd0;
  localparam logic [2:0] R_STAKE_LIM = 3'd1;
  localparam logic [2:0] R_STAKE_V2  = 3'd2;
  localparam logic [2:0] R_STAKE_RED = 3'd3;
  localparam logic [2:0] R_V2_TIME   = 3'd4;
  localparam logic [2:0] R_V3_TIME   = 3'd5;
  localparam logic [2:0] R_FIX_TIME  = 3'd6;
  localparam logic [2:0] R_RED_H     = 3'd7;

  localparam logic [1:0] POS_GENESIS = 2'd0;
  localparam logic [1:0] POS_NORMAL  = 2'd3;

  // Divisors (I+1)*S and multiplier bases (I-1)*S for the two spacings
  localparam int    I_V2  = TARGET_TIMESPAN / TARGET_SPACING;
  localparam int    I_V1  = TARGET_TIMESPAN / TARGET_SPACING_V1;
  localparam int    D_V2  = (I_V2 + 1) * TARGET_SPACING;
  localparam int    D_V1  = (I_V1 + 1) * TARGET_SPACING_V1;
  localparam longint MB_V2 = longint'(I_V2 - 1) * longint'(TARGET_SPACING);
  localparam longint MB_V1 = longint'(I_V1 - 1) * longint'(TARGET_SPACING_V1);

  localparam int NMC = 15;
  localparam int NDC = 32;
  localparam int NST = 1 + 2*NMC + NDC + 2;
  localparam int DV0 = 1 + 2*NMC;

  // ---------------- configuration registers ----------------
  logic [31:0] work_lim, stake_lim, stake_v2, stake_red, v2_time, v3_time, fix_time;
  logic [30:0] red_h;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      work_lim  <= 32'h1E0F_FFFF;
      stake_lim <= 32'h1E0F_FFFF;
      stake_v2  <= 32'h1E0F_FFFF;
      stake_red <= 32'h1E0F_FFFF;
      v2_time   <= 32'd0;
      v3_time   <= 32'd0;
      fix_time  <= 32'd0;
      red_h     <= 31'h7FFF_FFFF;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        R_WORK_LIM:  work_lim  <= pwdata;
        R_STAKE_LIM: stake_lim <= pwdata;
        R_STAKE_V2:  stake_v2  <= pwdata;
        R_STAKE_RED: stake_red <= pwdata;
        R_V2_TIME:   v2_time   <= pwdata;
        R_V3_TIME:   v3_time   <= pwdata;
        R_FIX_TIME:  fix_time  <= pwdata;
        R_RED_H:     red_h     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      R_WORK_LIM:  prdata = work_lim;
      R_STAKE_LIM: prdata = stake_lim;
      R_STAKE_V2:  prdata = stake_v2;
      R_STAKE_RED: prdata = stake_red;
      R_V2_TIME:   prdata = v2_time;
      R_V3_TIME:   prdata = v3_time;
      R_FIX_TIME:  prdata = fix_time;
      R_RED_H:     prdata = {1'b0, red_h};
      default:     prdata = 32'd0;
    endcase
  end

  // ---------------- stage valids and advance chain ----------------
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    en[NST-1] = !v[NST-1] || out_ch.ready;
    for (int i = NST-2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_ch.valid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // ---------------- setup stage ----------------
  logic               stake;
  logic [31:0]        lim_tip, lim_last, sel_c;
  logic               nort, dsel;
  logic signed [33:0] act, sp;
  logic signed [63:0] mult;
  ntr_pkg::mul_t      s0_next;
  ntr_pkg::mul_t      mc [0:NMC];

  always_comb begin
    stake = in_ch.proof_of_stake;
    // Limit chosen by proof type, height, then time
    if (!stake) begin
      lim_tip = work_lim;
    end else if (in_ch.new_height >= red_h) begin
      lim_tip = stake_red;
    end else if (in_ch.tip_time >= v2_time) begin
      lim_tip = stake_v2;
    end else begin
      lim_tip = stake_lim;
    end
    if (!stake) begin
      lim_last = work_lim;
    end else if (in_ch.new_height >= red_h) begin
      lim_last = stake_red;
    end else if (in_ch.last_time >= v2_time) begin
      lim_last = stake_v2;
    end else begin
      lim_last = stake_lim;
    end

    nort = stake ? (STAKE_NO_RETARGET != 0) : (WORK_NO_RETARGET != 0);
    if (in_ch.chain_position == POS_GENESIS) begin
      sel_c = work_lim;
    end else if (in_ch.chain_position != POS_NORMAL) begin
      sel_c = lim_tip;
    end else begin
      sel_c = lim_last;
    end

    // Actual spacing with the negative fix and the ten-spacing cap
    dsel = in_ch.last_time >= v2_time;
    sp   = dsel ? 34'(TARGET_SPACING) : 34'(TARGET_SPACING_V1);
    act  = $signed({2'b0, in_ch.last_time}) - $signed({2'b0, in_ch.first_time});
    if (in_ch.last_time >= fix_time && act < 0) begin
      act = sp;
    end
    if (in_ch.last_time >= v3_time && act > sp * 34'sd10) begin
      act = sp * 34'sd10;
    end
    mult = (dsel ? 64'(MB_V2) : 64'(MB_V1)) + 64'(act) + 64'(act);

    s0_next.acc           = '0;
    s0_next.t             = ntr_pkg::decode(in_ch.last_bits);
    s0_next.m             = mult;
    s0_next.side.fixed    = (in_ch.chain_position != POS_NORMAL) || nort;
    s0_next.side.alt      = (in_ch.chain_position == POS_NORMAL && nort) ?
                            in_ch.last_bits : ntr_pkg::enc_dec(sel_c);
    s0_next.side.lim_bits = lim_last;
    s0_next.side.dsel     = dsel;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mc[0] <= s0_next;
    end
  end

  // ---------------- multiply row ----------------
  for (genvar c = 0; c < NMC; c++) begin : g_mul
    ntr_mul_cell #(
      .LI ((c < 8) ? c : c - 8),
      .MJ ((c < 8) ? 0 : 1)
    ) u_cell (
      .clk  (clk),
      .en   (en[2*c+2 : 2*c+1]),
      .din  (mc[c]),
      .dout (mc[c+1])
    );
  end

  // ---------------- divide row ----------------
  ntr_pkg::div_t dc [0:NDC];

  always_comb begin
    dc[0].word  = mc[NMC].acc;
    dc[0].rem   = '0;
    dc[0].found = 1'b0;
    dc[0].n     = 2'd0;
    dc[0].sz    = 6'd0;
    dc[0].win   = 24'd0;
    dc[0].side  = mc[NMC].side;
  end

  for (genvar k = 0; k < NDC; k++) begin : g_div
    ntr_div_cell #(
      .BI (NDC - 1 - k),
      .D0 (D_V1),
      .D1 (D_V2)
    ) u_cell (
      .clk  (clk),
      .en   (en[DV0 + k]),
      .din  (dc[k]),
      .dout (dc[k+1])
    );
  end

  // ---------------- limit decode, range check, output ----------------
  ntr_pkg::div_t f1;
  logic [255:0]  lim256;
  logic [31:0]   out_bits;
  logic [31:0]   fin;
  logic [23:0]   cc;
  logic [7:0]    csz;

  always_ff @(posedge clk) begin
    if (en[NST-2]) begin
      f1     <= dc[NDC];
      lim256 <= ntr_pkg::decode(dc[NDC].side.lim_bits);
    end
  end

  always_comb begin
    cc  = f1.win;
    csz = {2'b0, f1.sz};
    // Keep the sign bit clear: drop a byte and grow the size
    if (cc[23]) begin
      cc  = cc >> 8;
      csz = csz + 8'd1;
    end
    if (f1.side.fixed || !f1.found || (f1.word > lim256)) begin
      fin = f1.side.alt;
    end else begin
      fin = {csz, cc};
    end
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_bits <= fin;
    end
  end

  assign out_ch.valid     = v[NST-1];
  assign out_ch.next_bits = out_bits;

`ifndef SYNTH
  // Backpressure reaches the input only when every stage holds an item.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (&v))
    else $error("input blocked with a bubble in the row");

  // An accepted item lands in the setup stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> v[0])
    else $error("accepted item lost at setup stage");

  // A result that is taken leaves unless the stage before refills it.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !v[NST-2]) |=> !out_ch.valid)
    else $error("delivered result repeated");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule
